FILE: rtl/lncm_pkg.sv
// Package with the shared types and constants of the cell map.
package lncm_pkg;

  localparam int DefMapWidth  = 64;
  localparam int DefMapHeight = 64;

  localparam logic [2:0] ACT_SET   = 3'd0;
  localparam logic [2:0] ACT_CLEAR = 3'd1;
  localparam logic [2:0] ACT_GEN   = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_WIPE  = 3'd4;

  localparam logic [4:0] ALIVE_BIT = 5'h01;
  localparam logic [4:0] COUNT_ONE = 5'h02;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_CHK_RD,
    ST_CHK,
    ST_COPY,
    ST_SCAN_RD,
    ST_SCAN,
    ST_CHG_RD,
    ST_CHG_WR,
    ST_WIPE,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/life_neighbor_count_cell_map_core.sv
// Top level of the toroidal Game of Life cell map with stored neighbor counts.
// One item is accepted at a time; each gives one result transfer. An item first brings its
// column and row onto the map, subtracting a map dimension from a coordinate until it lies
// on the map. A read then fetches the cell, a set or clear makes nine read-modify-writes of
// the cell memory (the cell and its eight neighbors), a redundant set or clear only checks
// the cell, a clear of the map writes every cell, and a generation step copies every cell
// into a snapshot, then scans it, with nine read-modify-writes for each cell that changes.
// A result that is still stalled holds the next one back. After reset the map is cleared
// by a pass over every cell during which no item is accepted.
module life_neighbor_count_cell_map_core
  import lncm_pkg::*;
#(
  parameter int MAP_WIDTH  = DefMapWidth,
  parameter int MAP_HEIGHT = DefMapHeight
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [5:0] col,
  input  logic [5:0] row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       cell_alive,
  output logic [3:0] live_neighbors,
  output logic       status
);

  localparam int XW    = $clog2(MAP_WIDTH);
  localparam int YW    = $clog2(MAP_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;

  state_t state, state_next;

  logic [4:0]    cmem [CELLS];
  logic [4:0]    smem [CELLS];
  logic [4:0]    crd;
  logic [4:0]    srd;

  logic [2:0]    act;
  logic [5:0]    rx;
  logic [5:0]    ry;
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic          stat;
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic          clive;
  logic [3:0]    nb;
  logic          booting;
  logic [AW-1:0] wptr;

  logic [XW-1:0] cx_next, sx_next;
  logic [YW-1:0] cy_next, sy_next;
  logic [5:0]    rx_next, ry_next;
  logic [XW-1:0] px_next;
  logic [YW-1:0] py_next;
  logic [3:0]    nb_next;
  logic          clive_next, stat_next, booting_next;
  logic [AW-1:0] wptr_next;
  logic [2:0]    act_next;

  logic [AW-1:0] raddr, waddr;
  logic          cwe, swe;
  logic [4:0]    wdata;
  logic [AW-1:0] saddr;

  logic [XW-1:0] tx;
  logic [YW-1:0] ty;
  logic [3:0]    cnt;
  logic [3:0]    cnt_new;
  logic          out_load;

  function automatic logic [AW-1:0] addr_of(logic [XW-1:0] x, logic [YW-1:0] y);
    addr_of = AW'(y) * AW'(MAP_WIDTH) + AW'(x);
  endfunction

  function automatic logic [XW-1:0] wrap_x(logic [XW-1:0] x, logic [1:0] d);
    logic [XW-1:0] r;
    r = x;
    if (d == 2'd0) begin
      r = (x == '0) ? XW'(MAP_WIDTH - 1) : x - XW'(1);
    end else if (d == 2'd2) begin
      r = (x == XW'(MAP_WIDTH - 1)) ? '0 : x + XW'(1);
    end
    wrap_x = r;
  endfunction

  function automatic logic [YW-1:0] wrap_y(logic [YW-1:0] y, logic [1:0] d);
    logic [YW-1:0] r;
    r = y;
    if (d == 2'd0) begin
      r = (y == '0) ? YW'(MAP_HEIGHT - 1) : y - YW'(1);
    end else if (d == 2'd2) begin
      r = (y == YW'(MAP_HEIGHT - 1)) ? '0 : y + YW'(1);
    end
    wrap_y = r;
  endfunction

  logic [1:0] nx, ny;

  always_comb begin
    nx = 2'd1;
    ny = 2'd1;
    unique case (nb)
      4'd0: begin nx = 2'd0; ny = 2'd0; end
      4'd1: begin nx = 2'd1; ny = 2'd0; end
      4'd2: begin nx = 2'd2; ny = 2'd0; end
      4'd3: begin nx = 2'd0; ny = 2'd1; end
      4'd4: begin nx = 2'd1; ny = 2'd1; end
      4'd5: begin nx = 2'd2; ny = 2'd1; end
      4'd6: begin nx = 2'd0; ny = 2'd2; end
      4'd7: begin nx = 2'd1; ny = 2'd2; end
      4'd8: begin nx = 2'd2; ny = 2'd2; end
      default: ;
    endcase
  end

  assign tx  = wrap_x(cx, nx);
  assign ty  = wrap_y(cy, ny);
  assign cnt = crd[4:1];

  always_comb begin
    cnt_new = cnt;
    if (clive) begin
      if (cnt < 4'd8) cnt_new = cnt + 4'd1;
    end else begin
      if (cnt > 4'd0) cnt_new = cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cwe) cmem[waddr] <= wdata;
    crd <= cmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (swe) smem[wptr] <= crd;
    srd <= smem[saddr];
  end

  assign in_stall = (state != ST_IDLE) || booting;
  assign out_load = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WIPE;
      booting   <= 1'b1;
      wptr      <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      booting <= booting_next;
      wptr    <= wptr_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act   <= act_next;
    rx    <= rx_next;
    ry    <= ry_next;
    px    <= px_next;
    py    <= py_next;
    stat  <= stat_next;
    sx    <= sx_next;
    sy    <= sy_next;
    cx    <= cx_next;
    cy    <= cy_next;
    clive <= clive_next;
    nb    <= nb_next;
    if (out_load) begin
      cell_alive     <= crd[0];
      live_neighbors <= crd[4:1];
      status         <= stat;
    end
  end

  always_comb begin
    state_next   = state;
    booting_next = booting;
    wptr_next    = wptr;
    act_next     = act;
    rx_next      = rx;
    ry_next      = ry;
    px_next      = px;
    py_next      = py;
    stat_next    = stat;
    sx_next      = sx;
    sy_next      = sy;
    cx_next      = cx;
    cy_next      = cy;
    clive_next   = clive;
    nb_next      = nb;
    raddr        = addr_of(px, py);
    saddr        = addr_of(sx, sy);
    waddr        = addr_of(tx, ty);
    wdata        = crd;
    cwe          = 1'b0;
    swe          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !booting) begin
          act_next   = action;
          rx_next    = col;
          ry_next    = row;
          stat_next  = 1'b0;
          sx_next    = '0;
          sy_next    = '0;
          wptr_next  = '0;
          state_next = ST_WRAP;
        end
      end
      ST_WRAP: begin
        raddr = '0;
        if (8'(rx) >= 8'(MAP_WIDTH)) begin
          rx_next = rx - 6'(MAP_WIDTH);
        end else if (8'(ry) >= 8'(MAP_HEIGHT)) begin
          ry_next = ry - 6'(MAP_HEIGHT);
        end else begin
          px_next = XW'(rx);
          py_next = YW'(ry);
          unique case (act)
            ACT_SET, ACT_CLEAR: state_next = ST_CHK_RD;
            ACT_GEN:            state_next = ST_COPY;
            ACT_WIPE:           state_next = ST_WIPE;
            default:            state_next = ST_OUT_RD;
          endcase
        end
      end
      ST_CHK_RD: state_next = ST_CHK;
      ST_CHK: begin
        if (crd[0] == (act == ACT_SET)) begin
          stat_next  = 1'b1;
          state_next = ST_OUT_RD;
        end else begin
          cx_next    = px;
          cy_next    = py;
          clive_next = (act == ACT_SET);
          nb_next    = 4'd0;
          state_next = ST_CHG_RD;
        end
      end
      ST_COPY: begin
        raddr = wptr + AW'(1);
        swe   = 1'b1;
        if (wptr == AW'(CELLS - 1)) begin
          state_next = ST_SCAN_RD;
        end else begin
          wptr_next = wptr + AW'(1);
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN;
      ST_SCAN: begin
        cx_next = sx;
        cy_next = sy;
        nb_next = 4'd0;
        if (srd[0] && srd[4:1] != 4'd2 && srd[4:1] != 4'd3) begin
          clive_next = 1'b0;
          state_next = ST_CHG_RD;
        end else if (!srd[0] && srd[4:1] == 4'd3) begin
          clive_next = 1'b1;
          state_next = ST_CHG_RD;
        end else if (sx == XW'(MAP_WIDTH - 1) && sy == YW'(MAP_HEIGHT - 1)) begin
          state_next = ST_OUT_RD;
        end else begin
          if (sx == XW'(MAP_WIDTH - 1)) begin
            sx_next = '0;
            sy_next = sy + YW'(1);
          end else begin
            sx_next = sx + XW'(1);
          end
          state_next = ST_SCAN_RD;
        end
      end
      ST_CHG_RD: begin
        raddr      = addr_of(tx, ty);
        state_next = ST_CHG_WR;
      end
      ST_CHG_WR: begin
        cwe = 1'b1;
        if (nb == 4'd4) begin
          wdata = {crd[4:1], clive};
        end else begin
          wdata = {cnt_new, crd[0]};
        end
        if (nb == 4'd8) begin
          if (act == ACT_GEN) begin
            if (sx == XW'(MAP_WIDTH - 1) && sy == YW'(MAP_HEIGHT - 1)) begin
              state_next = ST_OUT_RD;
            end else begin
              if (sx == XW'(MAP_WIDTH - 1)) begin
                sx_next = '0;
                sy_next = sy + YW'(1);
              end else begin
                sx_next = sx + XW'(1);
              end
              state_next = ST_SCAN_RD;
            end
          end else begin
            state_next = ST_OUT_RD;
          end
        end else begin
          nb_next    = nb + 4'd1;
          state_next = ST_CHG_RD;
        end
      end
      ST_WIPE: begin
        cwe   = 1'b1;
        waddr = wptr;
        wdata = '0;
        if (wptr == AW'(CELLS - 1)) begin
          wptr_next = '0;
          if (booting) begin
            booting_next = 1'b0;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_OUT_RD;
          end
        end else begin
          wptr_next = wptr + AW'(1);
        end
      end
      ST_OUT_RD: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (!out_valid || !out_stall) state_next = ST_OUT;
      end
      ST_OUT: begin
        raddr      = addr_of(px, py);
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  property p_stall_while_busy;
    @(posedge clk) disable iff (rst) (state != ST_IDLE) |-> in_stall;
  endproperty
  a_stall_while_busy: assert property (p_stall_while_busy)
    else $error("input taken while busy");

  property p_result_once;
    @(posedge clk) disable iff (rst) (state == ST_OUT) |=> (state == ST_IDLE) && out_valid;
  endproperty
  a_result_once: assert property (p_result_once)
    else $error("result not presented");

  property p_no_overwrite;
    @(posedge clk) disable iff (rst) (state == ST_OUT) |-> !(out_valid && out_stall);
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("stalled result overwritten");

  property p_neighbor_index;
    @(posedge clk) disable iff (rst) (state == ST_CHG_WR) |-> (nb <= 4'd8);
  endproperty
  a_neighbor_index: assert property (p_neighbor_index)
    else $error("neighbor index out of range");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the toroidal Game of Life cell map core.
module tb;
  import lncm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = DefMapWidth;
  localparam int H = DefMapHeight;
  localparam int CELL_COUNT = W * H;
  localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [2:0] ACT_SPARE_MID = 3'd6;
  localparam logic [2:0] ACT_SPARE     = 3'd7;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic       alive;
    logic [3:0] count;
    logic       ignored;
  } cell_report_t;

  typedef struct {
    logic [2:0] act;
    logic [5:0] c;
    logic [5:0] r;
    bit         typed;
    cell_report_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] action = '0;
  logic [5:0] col = '0;
  logic [5:0] row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cell_alive;
  logic [3:0] live_neighbors;
  logic status;

  logic [4:0] map_words [CELL_COUNT];
  logic [4:0] frozen_words [CELL_COUNT];
  cell_report_t pending_reports[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  life_neighbor_count_cell_map_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("life_neighbor_count_cell_map_core regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic void adjust_count(int idx, bit up);
    logic [3:0] n;
    n = map_words[idx][4:1];
    if (up && n < 4'd8) n++;
    if (!up && n > 4'd0) n--;
    map_words[idx] = {n, map_words[idx][0]};
  endfunction

  function automatic void flip_cell(int x, int y, bit live);
    int dx;
    int dy;
    map_words[y * W + x][0] = live;
    for (dy = -1; dy <= 1; dy++)
      for (dx = -1; dx <= 1; dx++)
        if (dx != 0 || dy != 0)
          adjust_count(((y + dy + H) % H) * W + (x + dx + W) % W, live);
  endfunction

  function automatic cell_report_t predict_cell(logic [2:0] act, logic [5:0] c, logic [5:0] r);
    int x;
    int y;
    int idx;
    int i;
    logic [3:0] n;
    cell_report_t rep;
    x = c % W;
    y = r % H;
    idx = y * W + x;
    rep.ignored = 1'b0;
    case (act)
      ACT_SET: begin
        if (map_words[idx][0]) rep.ignored = 1'b1;
        else flip_cell(x, y, 1'b1);
      end
      ACT_CLEAR: begin
        if (!map_words[idx][0]) rep.ignored = 1'b1;
        else flip_cell(x, y, 1'b0);
      end
      ACT_GEN: begin
        for (i = 0; i < CELL_COUNT; i++) frozen_words[i] = map_words[i];
        for (i = 0; i < CELL_COUNT; i++) begin
          n = frozen_words[i][4:1];
          if (frozen_words[i][0] && n != 4'd2 && n != 4'd3) flip_cell(i % W, i / W, 1'b0);
          else if (!frozen_words[i][0] && n == 4'd3) flip_cell(i % W, i / W, 1'b1);
        end
      end
      ACT_WIPE: begin
        for (i = 0; i < CELL_COUNT; i++) map_words[i] = '0;
      end
      default: ;
    endcase
    rep.alive = map_words[idx][0];
    rep.count = map_words[idx][4:1];
    return rep;
  endfunction

  task automatic send_item(logic [2:0] act, logic [5:0] c, logic [5:0] r, bit typed,
                           cell_report_t want);
    cell_report_t rep;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    col <= c;
    row <= r;
    do @(posedge clk); while (in_stall);
    rep = predict_cell(act, c, r);
    if (typed && rep != want)
      report_mismatch("typed row disagrees with predictor", rep, want);
    pending_reports.push_back(typed ? want : rep);
  endtask

  always @(posedge clk) begin
    cell_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = pending_reports.pop_front();
        if (cell_alive !== want.alive) report_mismatch("cell_alive", cell_alive, want.alive);
        if (live_neighbors !== want.count)
          report_mismatch("live_neighbors", live_neighbors, want.count);
        if (status !== want.ignored) report_mismatch("status", status, want.ignored);
      end
    end
  end

  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (k = 0; k < 200; k++) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    stim_row_t plan[$];
    int i;
    int k;
    int x;
    int y;
    logic [2:0] a;
    for (i = 0; i < CELL_COUNT; i++) map_words[i] = '0;
    plan = '{
      '{ACT_READ, 6'd0, 6'd0, 1'b1, '{1'b0, 4'd0, 1'b0}},
      '{ACT_CLEAR, 6'd63, 6'd63, 1'b1, '{1'b0, 4'd0, 1'b1}},
      '{ACT_SET, 6'd0, 6'd0, 1'b1, '{1'b1, 4'd0, 1'b0}},
      '{ACT_SET, 6'd0, 6'd0, 1'b1, '{1'b1, 4'd0, 1'b1}},
      '{ACT_READ, 6'd63, 6'd63, 1'b1, '{1'b0, 4'd1, 1'b0}},
      '{ACT_SET, 6'd63, 6'd0, 1'b0, '{1'b0, 4'd0, 1'b0}},
      '{ACT_SET, 6'd1, 6'd0, 1'b0, '{1'b0, 4'd0, 1'b0}},
      '{ACT_READ, 6'd0, 6'd63, 1'b1, '{1'b0, 4'd3, 1'b0}},
      '{ACT_GEN, 6'd0, 6'd1, 1'b0, '{1'b0, 4'd0, 1'b0}},
      '{ACT_GEN, 6'd0, 6'd63, 1'b0, '{1'b0, 4'd0, 1'b0}},
      '{ACT_SPARE, 6'd0, 6'd0, 1'b0, '{1'b0, 4'd0, 1'b0}},
      '{ACT_SPARE_LO, 6'd1, 6'd0, 1'b0, '{1'b0, 4'd0, 1'b0}},
      '{ACT_SPARE_MID, 6'd42, 6'd21, 1'b0, '{1'b0, 4'd0, 1'b0}},
      '{ACT_CLEAR, 6'd0, 6'd0, 1'b0, '{1'b0, 4'd0, 1'b0}},
      '{ACT_WIPE, 6'd0, 6'd0, 1'b1, '{1'b0, 4'd0, 1'b0}},
      '{ACT_READ, 6'd1, 6'd0, 1'b1, '{1'b0, 4'd0, 1'b0}}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i])
      send_item(plan[i].act, plan[i].c, plan[i].r, plan[i].typed, plan[i].want);
    hold_off = 1'b1;
    for (i = 0; i < 8; i++) begin
      x = $urandom_range(0, 63);
      y = $urandom_range(0, 63);
      send_item(ACT_SET, 6'(x), 6'(y), 1'b0, '0);
    end
    for (i = 0; i < 120; i++) begin
      if (i == 100) calm = 1'b1;
      k = $urandom_range(0, 99);
      x = $urandom_range(0, 7);
      y = $urandom_range(0, 7);
      if (k < 6) a = ACT_GEN;
      else if (k < 8) a = ACT_WIPE;
      else if (k < 11) a = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE));
      else if (k < 55) a = ACT_SET;
      else if (k < 75) a = ACT_CLEAR;
      else a = ACT_READ;
      if ($urandom_range(0, 5) == 0) begin
        x = $urandom_range(0, 63);
        y = $urandom_range(0, 63);
      end
      send_item(a, 6'(x), 6'(y), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("life_neighbor_count_cell_map_core regression: pass");
    end else begin
      $display("life_neighbor_count_cell_map_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: life_neighbor_count_cell_map_core.f
rtl/lncm_pkg.sv
rtl/life_neighbor_count_cell_map_core.sv
dv/tb.sv
